FILE: hw/rtl/ira_pkg.sv
// Shared types, sizes and helpers for the interval room assigner.
// Depends on nothing; imported by interval_room_assigner.
`default_nettype none

package ira_pkg;

	localparam int MAX_ROOMS  = 256;
	localparam int TIME_W     = 32;
	localparam int ID_W       = 16;
	localparam int ROOM_OUT_W = 9;
	localparam int ADDR_W     = $clog2(MAX_ROOMS);
	localparam int CNT_W      = $clog2(MAX_ROOMS + 1);
	localparam int CHILD_W    = ADDR_W + 2;

	typedef enum logic [2:0] {
		ST_REUSED  = 3'd0,
		ST_NEW     = 3'd1,
		ST_OVERFLOW = 3'd2,
		ST_ORDER   = 3'd3,
		ST_CLEARED = 3'd4
	} status_t;

	typedef enum logic {
		ACT_ASSIGN = 1'b0,
		ACT_CLEAR  = 1'b1
	} action_t;

	// one heap slot: time the room is free again, and its room number
	typedef struct packed {
		logic [TIME_W-1:0] free_time;
		logic [CNT_W-1:0]  room;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	// true when slot a belongs above slot b; ties go to the lower room
	function automatic logic slot_before(input slot_t a, input slot_t b);
		if (a.free_time != b.free_time)
			return a.free_time < b.free_time;
		return a.room < b.room;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/ira_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none

module ira_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

FILE: hw/rtl/interval_room_assigner.sv
// Interval room assigner top level: control FSM around a heap RAM.
// Depends on ira_pkg and ira_ram.
//
// Usage:
//   Input: drive action, interval_id, start_time, end_time with start high;
//   the beat is taken at a rising edge where busy is low. Intervals come in
//   nondecreasing start order; action clear empties all rooms.
//   Output: one result per beat, shown for exactly one cycle with done high.
//   Clear and out-of-order beats: result in the cycle after acceptance, busy
//   stays low, so a new beat may follow at once.
//   Assign beats: slot 0 is read while idle, S_TOP registers the result,
//   then the heap is repaired in place while busy is high.
//   Reuse sifts down, reading both children together in S_DN_RD and
//   writing one slot in S_DN_CMP at each level. New rooms sift up, reading
//   the parent in S_UP_RD and writing in S_UP_CMP at each level; at the
//   root S_UP_RD writes the slot. The registered RAM read sets this split.
//   Overflow results pass through S_TOP and change neither count nor heap.
//   Reset clears the room count and last start; heap slots above the count
//   are never used, so the RAM needs no clearing. The receiver cannot stall.
`default_nettype none

module interval_room_assigner (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic                             action,
	input  wire logic [ira_pkg::ID_W-1:0]         interval_id,
	input  wire logic [ira_pkg::TIME_W-1:0]       start_time,
	input  wire logic [ira_pkg::TIME_W-1:0]       end_time,
	output logic                                  done,
	output logic      [ira_pkg::ROOM_OUT_W-1:0]   assigned_room,
	output logic      [ira_pkg::ID_W-1:0]         echoed_id,
	output logic      [ira_pkg::ROOM_OUT_W-1:0]   rooms_in_use,
	output ira_pkg::status_t                      status
);

	import ira_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TOP,
		S_DN_RD,
		S_DN_CMP,
		S_UP_RD,
		S_UP_CMP
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [TIME_W-1:0]     prev_q;
	logic [ADDR_W-1:0]     hole_q;
	slot_t                 node_q;
	logic [ID_W-1:0]       id_q;
	logic [TIME_W-1:0]     start_q;
	logic [TIME_W-1:0]     end_q;
	logic                  done_q;
	logic [ROOM_OUT_W-1:0] room_out_q;
	logic [ID_W-1:0]       id_out_q;
	logic [ROOM_OUT_W-1:0] cnt_out_q;
	status_t               status_q;

	logic                  we;
	logic [ADDR_W-1:0]     waddr;
	slot_t                 wdata;
	logic [ADDR_W-1:0]     raddr_a;
	logic [ADDR_W-1:0]     raddr_b;
	slot_t                 rd_a;
	slot_t                 rd_b;

	logic [CHILD_W-1:0]    left_c;
	logic [CHILD_W-1:0]    right_c;
	logic                  left_ok;
	logic                  right_ok;
	logic                  l_before;
	logic                  r_before;
	slot_t                 best_lc;
	logic [ADDR_W-1:0]     parent_c;
	logic                  up_swap;
	logic                  accept;
	logic                  reuse;
	logic [CNT_W-1:0]      cnt_inc;

	ira_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(MAX_ROOMS)
	) u_heap (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	assign accept  = start && (state_q == S_IDLE);
	assign cnt_inc = cnt_q + CNT_W'(1);
	assign reuse   = (cnt_q != '0) && (rd_a.free_time <= start_q);

	always_comb begin
		left_c   = CHILD_W'({hole_q, 1'b0}) + CHILD_W'(1);
		right_c  = left_c + CHILD_W'(1);
		left_ok  = left_c < CHILD_W'(cnt_q);
		right_ok = right_c < CHILD_W'(cnt_q);
		l_before = left_ok && slot_before(rd_a, node_q);
		best_lc  = l_before ? rd_a : node_q;
		r_before = right_ok && slot_before(rd_b, best_lc);
		parent_c = (hole_q - ADDR_W'(1)) >> 1;
		up_swap  = slot_before(node_q, rd_a);
	end

	// RAM port steering
	always_comb begin
		we      = 1'b0;
		waddr   = hole_q;
		wdata   = node_q;
		raddr_a = '0;
		raddr_b = right_c[ADDR_W-1:0];
		case (state_q)
			S_DN_RD: begin
				raddr_a = left_c[ADDR_W-1:0];
			end
			S_DN_CMP: begin
				we    = 1'b1;
				wdata = r_before ? rd_b : best_lc;
			end
			S_UP_RD: begin
				raddr_a = parent_c;
				we      = (hole_q == '0);
			end
			S_UP_CMP: begin
				we    = 1'b1;
				wdata = up_swap ? rd_a : node_q;
			end
			default: begin
				raddr_a = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			prev_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						id_q     <= interval_id;
						start_q  <= start_time;
						end_q    <= end_time;
						id_out_q <= interval_id;
						if (action == ACT_CLEAR) begin
							cnt_q      <= '0;
							prev_q     <= '0;
							done_q     <= 1'b1;
							room_out_q <= '0;
							cnt_out_q  <= '0;
							status_q   <= ST_CLEARED;
						end else if (start_time < prev_q) begin
							done_q     <= 1'b1;
							room_out_q <= '0;
							cnt_out_q  <= ROOM_OUT_W'(cnt_q);
							status_q   <= ST_ORDER;
						end else begin
							state_q <= S_TOP;
						end
					end
				end
				S_TOP: begin
					done_q   <= 1'b1;
					id_out_q <= id_q;
					if (reuse) begin
						prev_q          <= start_q;
						node_q.free_time <= end_q;
						node_q.room     <= rd_a.room;
						hole_q          <= '0;
						room_out_q      <= ROOM_OUT_W'(rd_a.room);
						cnt_out_q       <= ROOM_OUT_W'(cnt_q);
						status_q        <= ST_REUSED;
						state_q         <= S_DN_RD;
					end else if (cnt_q >= CNT_W'(MAX_ROOMS)) begin
						room_out_q <= '0;
						cnt_out_q  <= ROOM_OUT_W'(cnt_q);
						status_q   <= ST_OVERFLOW;
						state_q    <= S_IDLE;
					end else begin
						prev_q          <= start_q;
						cnt_q           <= cnt_inc;
						node_q.free_time <= end_q;
						node_q.room     <= cnt_inc;
						hole_q          <= cnt_q[ADDR_W-1:0];
						room_out_q      <= ROOM_OUT_W'(cnt_inc);
						cnt_out_q       <= ROOM_OUT_W'(cnt_inc);
						status_q        <= ST_NEW;
						state_q         <= S_UP_RD;
					end
				end
				S_DN_RD: begin
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					// the winning child moved into the hole; follow it down
					if (r_before) begin
						hole_q  <= right_c[ADDR_W-1:0];
						state_q <= S_DN_RD;
					end else if (l_before) begin
						hole_q  <= left_c[ADDR_W-1:0];
						state_q <= S_DN_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_UP_RD: begin
					state_q <= (hole_q == '0) ? S_IDLE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (up_swap) begin
						hole_q  <= parent_c;
						state_q <= S_UP_RD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign assigned_room = room_out_q;
	assign echoed_id     = id_out_q;
	assign rooms_in_use  = cnt_out_q;
	assign status        = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ROOMS))
		else $error("room count above capacity");

	a_top_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TOP) |=> done)
		else $error("assign beat gave no result");

	a_clear_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && action == ACT_CLEAR) |=> (done && status == ST_CLEARED && cnt_q == '0))
		else $error("clear beat mishandled");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> busy)
		else $error("heap write while idle");

	a_new_room: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_NEW) |-> (assigned_room == rooms_in_use))
		else $error("new room number differs from count");

endmodule

`default_nettype wire
